FILE: src/firs_pkg.sv
// ----------------------------------------------------------------------------
// firs_pkg
// Shared types and constants for the streaming FIR filter
// ----------------------------------------------------------------------------
package firs_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 16;
    localparam int FRAC_BITS      = 15;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    localparam int TAP_COUNT_BITS = 7;
    localparam int TAP_INDEX_BITS = 6;

    localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = 7'd64;

    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_FILTER = 1'b1
    } op_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    typedef struct packed
    {
        op_t                                 operation;
        logic [TAP_INDEX_BITS-1:0]           tap_index;
        logic signed [COEF_BITS-1:0]         coefficient;
        logic signed [SAMPLE_BITS-1:0]       sample_in;
    } in_word_t;

    typedef struct packed
    {
        logic signed [SAMPLE_BITS-1:0]       sample_out;
        logic                                clipped;
    } out_word_t;

    typedef struct packed
    {
        logic                                shift_en;
        logic                                load_en;
        logic [TAP_INDEX_BITS-1:0]           load_index;
        logic signed [COEF_BITS-1:0]         coef;
        logic [TAP_COUNT_BITS-1:0]           tap_count;
    } cell_ctrl_t;

endpackage

FILE: src/firs_cell.sv
// ----------------------------------------------------------------------------
// firs_cell
// One filter tap: delay register, weight register and a multiply-add
// stage on the partial sum that runs down the row
// ----------------------------------------------------------------------------
module firs_cell
    import firs_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int ACC_W = 38
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_ctrl_t                    ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample_left,
    input  logic signed [ACC_W-1:0]       psum_in,
    output logic signed [SAMPLE_BITS-1:0] sample_right,
    output logic signed [ACC_W-1:0]       psum_out
);

    logic signed [SAMPLE_BITS-1:0] delay_reg;
    logic signed [COEF_BITS-1:0]   weight_reg;
    logic signed [ACC_W-1:0]       psum_reg;
    logic signed [ACC_W-1:0]       psum_next;
    logic signed [PROD_BITS-1:0]   prod;
    logic signed [ACC_W-1:0]       term;
    logic                          active;
    logic                          load_hit;

    assign active   = int'(ctrl.tap_count) > INDEX;
    assign load_hit = ctrl.load_en && (int'(ctrl.load_index) == INDEX);

    assign prod      = weight_reg * delay_reg;
    assign term      = active ? {{(ACC_W-PROD_BITS){prod[PROD_BITS-1]}}, prod} : '0;
    assign psum_next = psum_in + term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
        end
        else if (ctrl.shift_en)
        begin
            delay_reg <= sample_left;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            weight_reg <= ctrl.coef;
        end
        psum_reg <= psum_next;
    end

    assign sample_right = delay_reg;
    assign psum_out     = psum_reg;

endmodule

FILE: src/fir_filter_stream_unit.sv
// ----------------------------------------------------------------------------
// fir_filter_stream_unit
// A sample word starts a run in which the partial sum walks the row of tap
// cells one cell per cycle; no word is accepted until the run ends with the
// result captured. A load word is taken only while idle and starts no run.
// The output register frees the input side while a result waits to be taken.
// Reset: delay line cleared, tap_count set to 64, weights undefined until loaded.
// ----------------------------------------------------------------------------
module fir_filter_stream_unit
    import firs_pkg::*;
#(
    parameter int MAX_TAPS = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  in_word_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output out_word_t                 out_data,
    input  logic                      cfg_we,
    input  logic [TAP_COUNT_BITS-1:0] cfg_wdata
);

    localparam int ACC_W = PROD_BITS + $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int UP_W  = ACC_W - SAMPLE_BITS + 1;

    state_t                    state_reg;
    state_t                    state_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic [TAP_COUNT_BITS-1:0] tap_count_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    out_word_t                 out_data_reg;
    out_word_t                 sat_word;
    logic                      capture;
    logic                      in_fire;
    logic                      chain_done;
    cell_ctrl_t                ctrl;

    logic signed [SAMPLE_BITS-1:0] smp  [0:MAX_TAPS-1];
    logic signed [ACC_W-1:0]       psum [0:MAX_TAPS];

    logic signed [ACC_W-1:0] q;
    logic [UP_W-1:0]         upper;
    logic                    ovf;

    // configuration

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            tap_count_reg <= cfg_wdata;
        end
    end

    // cell row

    assign in_fire = in_valid && in_ready;

    assign ctrl.shift_en   = in_fire && (in_data.operation == OP_FILTER);
    assign ctrl.load_en    = in_fire && (in_data.operation == OP_LOAD);
    assign ctrl.load_index = in_data.tap_index;
    assign ctrl.coef       = in_data.coefficient;
    assign ctrl.tap_count  = tap_count_reg;

    assign psum[0] = '0;

    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        if (k == 0)
        begin : g_first
            firs_cell #(
                .INDEX (k),
                .ACC_W (ACC_W)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .sample_left  (in_data.sample_in),
                .psum_in      (psum[k]),
                .sample_right (smp[k]),
                .psum_out     (psum[k+1])
            );
        end
        else
        begin : g_rest
            firs_cell #(
                .INDEX (k),
                .ACC_W (ACC_W)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .sample_left  (smp[k-1]),
                .psum_in      (psum[k]),
                .sample_right (smp[k]),
                .psum_out     (psum[k+1])
            );
        end
    end

    // shift, saturate

    assign q     = psum[MAX_TAPS] >>> FRAC_BITS;
    assign upper = q[ACC_W-1:SAMPLE_BITS-1];
    assign ovf   = !((&upper) || !(|upper));

    always_comb
    begin
        sat_word.clipped = ovf;
        if (ovf)
        begin
            sat_word.sample_out = q[ACC_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                             : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        else
        begin
            sat_word.sample_out = q[SAMPLE_BITS-1:0];
        end
    end

    // sequencer

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign chain_done = (cnt_reg == CNT_W'(MAX_TAPS));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        capture    = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = '0;
                if (in_valid && in_data.operation == OP_FILTER)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!chain_done)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    capture    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            out_data_reg <= sat_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks

    a_no_accept_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> !in_fire)
        else $error("word accepted while the tap row is busy");

    a_run_not_early: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && !chain_done) |=> state_reg == ST_RUN)
        else $error("run ended before the partial sum left the row");

    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RUN && chain_done))
        else $error("result word appeared without a finished run");

    a_filter_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.operation == OP_FILTER) |=> (state_reg == ST_RUN && cnt_reg == '0))
        else $error("sample word did not start a run");

endmodule

FILE: dv/fir_filter_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_stream_checker
// Watches the config port and both word channels of the FIR filter, keeps its
// own copy of the delay line, the tap weights and the tap count, predicts each
// filtered sample and compares it field by field with the word that comes out.
// ----------------------------------------------------------------------------
module fir_filter_stream_checker
    import firs_pkg::*;
#(
    parameter int MAX_TAPS = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  in_word_t                  in_data,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  out_word_t                 out_data,
    input  logic                      cfg_we,
    input  logic [TAP_COUNT_BITS-1:0] cfg_wdata,
    output int                        errors,
    output int                        pending
);

    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    logic signed [SAMPLE_BITS-1:0] history [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   weights [MAX_TAPS];
    logic [TAP_COUNT_BITS-1:0]     taps_in_use;
    out_word_t                     filtered_q [$];

    function automatic out_word_t filter_sample(input logic signed [SAMPLE_BITS-1:0] s);
        longint    acc;
        longint    q;
        int        n;
        out_word_t r;
        for (int k = MAX_TAPS - 1; k > 0; k--)
            history[k] = history[k-1];
        history[0] = s;
        n = (taps_in_use > MAX_TAPS) ? MAX_TAPS : int'(taps_in_use);
        acc = 0;
        for (int k = 0; k < n; k++)
            acc += longint'(weights[k]) * longint'(history[k]);
        q = acc >>> FRAC_BITS;
        r.clipped = 1'b0;
        if (q > SAT_HI)
        begin
            q = SAT_HI;
            r.clipped = 1'b1;
        end
        else if (q < SAT_LO)
        begin
            q = SAT_LO;
            r.clipped = 1'b1;
        end
        r.sample_out = q[SAMPLE_BITS-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_TAPS; k++)
            begin
                history[k] = '0;
                weights[k] = '0;
            end
            taps_in_use = TAP_COUNT_RESET;
            filtered_q.delete();
            pending = 0;
            errors  = 0;
        end
        else
        begin
            if (cfg_we)
                taps_in_use = cfg_wdata;
            if (out_valid && out_ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $display("%0t: unexpected output word, expected none, got sample_out=%0d clipped=%0b",
                             $time, out_data.sample_out, out_data.clipped);
                    errors++;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (out_data.sample_out !== want.sample_out)
                    begin
                        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                                 $time, want.sample_out, out_data.sample_out);
                        errors++;
                    end
                    if (out_data.clipped !== want.clipped)
                    begin
                        $display("%0t: clipped mismatch, expected %0b, got %0b",
                                 $time, want.clipped, out_data.clipped);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (in_data.operation == OP_LOAD)
                    weights[in_data.tap_index] = in_data.coefficient;
                else
                    filtered_q.push_back(filter_sample(in_data.sample_in));
            end
            pending = filtered_q.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives coefficient loads and samples into the FIR filter in random bursts
// over a series of tap count settings, stalls the output side on its own
// pattern, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
    import firs_pkg::*;

    localparam int     MAX_TAPS        = 64;
    localparam int     CLK_PERIOD      = 10;
    localparam int     NUM_PHASES      = 12;
    localparam int     ITEMS_PER_PHASE = 80;
    localparam longint CYCLE_LIMIT     = 1000000;

    localparam logic signed [15:0] S_MIN = 16'sh8000;
    localparam logic signed [15:0] S_MAX = 16'sh7FFF;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    in_word_t                  in_data   = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    out_word_t                 out_data;
    logic                      cfg_we    = 1'b0;
    logic [TAP_COUNT_BITS-1:0] cfg_wdata = '0;

    int                        errors;
    int                        pending;
    longint                    cycles     = 0;
    int                        burst_left = 0;
    logic [MAX_TAPS-1:0]       loaded     = '0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    fir_filter_stream_unit #(
        .MAX_TAPS (MAX_TAPS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    fir_filter_stream_checker #(
        .MAX_TAPS (MAX_TAPS)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_value(input int scale);
        logic signed [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 15))
            0:       return S_MIN;
            1:       return S_MAX;
            default: return v >>> scale;
        endcase
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_load(input int idx, input logic signed [15:0] c);
        in_word_t w;
        w.operation   = OP_LOAD;
        w.tap_index   = TAP_INDEX_BITS'(idx);
        w.coefficient = c;
        w.sample_in   = 16'($urandom);
        loaded[idx]   = 1'b1;
        send_word(w);
    endtask

    task automatic send_sample(input logic signed [15:0] s);
        in_word_t w;
        w.operation   = OP_FILTER;
        w.tap_index   = TAP_INDEX_BITS'($urandom);
        w.coefficient = 16'($urandom);
        w.sample_in   = s;
        send_word(w);
    endtask

    // stop sending and wait until every predicted result has been taken
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (MAX_TAPS + 8) @(negedge clk);
    endtask

    task automatic write_tap_count(input int n);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= TAP_COUNT_BITS'(n);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : receiver
        int window;
        int mode;
        int hold;
        int taken;
        int next_hold;
        int holds_done;
        window     = 0;
        mode       = 0;
        hold       = 0;
        taken      = 0;
        next_hold  = 40;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                taken++;
            // long hold-off so the filter backs up into its input
            if (holds_done < 2 && taken >= next_hold)
            begin
                hold = 500;
                holds_done++;
                next_hold = taken + 260;
            end
            @(negedge clk);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
            begin
                if (window == 0)
                begin
                    window = $urandom_range(16, 96);
                    mode   = $urandom_range(0, 2);
                end
                window--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int settings [6];
        int phase;
        int n;
        int scale;
        int k;
        int i;
        settings = '{1, 64, 127, 0, 65, 32};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero tap count: samples still shift, output stays zero
        write_tap_count(0);
        send_load(0, S_MIN);
        send_load(1, S_MIN);
        send_load(MAX_TAPS - 1, S_MAX);
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        settle();

        // two taps at full scale to hit both saturation limits
        write_tap_count(2);
        send_sample(S_MIN);
        send_sample(S_MIN);
        send_sample(S_MAX);
        send_sample(S_MAX);
        send_load(1, S_MAX);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase < 6)
                n = settings[phase];
            else if ($urandom_range(0, 3) == 0)
                n = $urandom_range(0, 127);
            else
                n = $urandom_range(1, 16);
            scale = $urandom_range(0, 12);
            settle();
            write_tap_count(n);
            for (k = 0; k < MAX_TAPS && k < n; k++)
                if (!loaded[k])
                    send_load(k, rand_value(scale));
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if ($urandom_range(0, 9) < 4)
                    send_load($urandom_range(0, MAX_TAPS - 1), rand_value(scale));
                else
                    send_sample(rand_value($urandom_range(0, 1) ? 0 : scale));
            end
        end

        settle();
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: fir_filter_stream_unit.f
src/firs_pkg.sv
src/firs_cell.sv
src/fir_filter_stream_unit.sv
dv/fir_filter_stream_checker.sv
dv/tb_top.sv
